// File: src/sfr_pkg.sv
package sfr_pkg;

    // Frame layout
    localparam int FRAME_BYTES   = 24;
    localparam int CRC_BYTES     = 22;
    localparam int PAYLOAD_START = 4;
    localparam int SHADOW_BYTES  = CRC_BYTES - PAYLOAD_START;
    localparam int COUNT_SAT     = 25;
    localparam int COUNT_W       = 5;
    localparam int SHADOW_IDX_W  = $clog2(SHADOW_BYTES);

    localparam logic [7:0]  MAGIC_0   = 8'h52;  // 'R'
    localparam logic [7:0]  MAGIC_1   = 8'h4C;  // 'L'
    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [15:0] CRC_POLY  = 16'h1021;
    localparam int          AGE_W     = 17;
    localparam logic [AGE_W-1:0] AGE_MAX = '1;

    // Stream widths
    localparam int S_TDATA_W = 8;
    localparam int S_TUSER_W = 5;
    localparam int M_TDATA_W = 184;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam int NUM_COUNTERS = 8;

    typedef enum logic [1:0] {
        MODE_BYTE = 2'd0,
        MODE_TICK = 2'd1,
        MODE_READ = 2'd2,
        MODE_NONE = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        VERDICT_NONE    = 3'd0,
        VERDICT_OK      = 3'd1,
        VERDICT_LENGTH  = 3'd2,
        VERDICT_MAGIC   = 3'd3,
        VERDICT_VERSION = 3'd4,
        VERDICT_TYPE    = 3'd5,
        VERDICT_CRC     = 3'd6
    } verdict_t;

    typedef enum logic [1:0] {
        LINK_OFF       = 2'd0,
        LINK_NO_PACKET = 2'd1,
        LINK_STALE     = 2'd2,
        LINK_UP        = 2'd3
    } link_t;

    typedef enum logic [1:0] {
        CFG_ENABLE      = 2'd0,
        CFG_STALE_LIMIT = 2'd1,
        CFG_VERSION     = 2'd2,
        CFG_TYPE        = 2'd3
    } cfg_reg_t;

    // Counter slots
    localparam logic [2:0] CNT_RAW     = 3'd0;
    localparam logic [2:0] CNT_VALID   = 3'd1;
    localparam logic [2:0] CNT_INVALID = 3'd2;

    // CRC-16/CCITT-FALSE, one byte, MSB first
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// File: src/status_frame_receiver_unit.sv
// Status frame receiver.
// Input stream (s_*): one word per item. s_tuser[1:0] is the mode (frame byte,
// millisecond tick, counter read), s_tuser[4:2] the counter select, s_tdata the
// frame byte and s_tlast the end of a frame. Frames must be 24 bytes, start
// with "RL", carry the configured version and type, and end with a
// little-endian CRC-16/CCITT-FALSE over bytes 0..21.
// Output stream (m_*): one result word per input word: verdict, link state,
// the fields of the last good frame and the counter read value.
// Config port (cfg_*): always ready; write only while the block is idle.
// m_tvalid rises once a word has passed the input register, then the result
// register. Throughput: one word per cycle while m_tready is high; the CRC
// byte update and the header checks sit in the single logic stage between the
// two registers. A stalled m_tready holds the result word; the input register
// still takes one more word, then s_tready drops until the result is taken.
// Reset (aresetn low, synchronous) disables the receiver, loads the default
// limits, clears counters, latched fields and link age, and empties both
// registers. Disabling via config forgets the last packet seen.
module status_frame_receiver_unit #(
    parameter int COUNTER_WIDTH = 32
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // input stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [sfr_pkg::S_TDATA_W-1:0]    s_tdata,   // data_byte[7:0]
    input  logic [sfr_pkg::S_TUSER_W-1:0]    s_tuser,   // mode[1:0], counter_select[4:2]
    input  logic                             s_tlast,   // frame_last
    // result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // frame_verdict[2:0], link_state[4:3], sequence_res[36:5], uptime_s[68:37],
    // camera_count[84:69], wifi_count[100:85], ble_count[116:101],
    // device_state[124:117], gps_state[132:125], capture_state[140:133],
    // gateway_rssi[148:141], count_value[180:149], zero pad[183:181]
    output logic [sfr_pkg::M_TDATA_W-1:0]    m_tdata,
    // config writes
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [sfr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sfr_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import sfr_pkg::*;

    // config registers
    logic        enable_reg;
    logic [15:0] stale_limit_reg;
    logic [7:0]  exp_version_reg;
    logic [7:0]  exp_type_reg;

    // input register
    logic        in_valid_reg;
    logic [1:0]  in_mode_reg;
    logic [7:0]  in_data_reg;
    logic        in_last_reg;
    logic [2:0]  in_sel_reg;

    // frame assembly
    logic [COUNT_W-1:0] byte_count_reg, byte_count_next;
    logic [15:0]        crc_reg, crc_next;
    verdict_t           fault_reg, fault_next;
    logic [7:0]         shadow_reg [SHADOW_BYTES];
    logic [7:0]         crc_low_reg;

    // link health
    logic               seen_reg, seen_next;
    logic [AGE_W-1:0]   age_reg, age_next;

    // latched payload fields
    logic [31:0]        seq_reg, seq_next;
    logic [31:0]        uptime_reg, uptime_next;
    logic [15:0]        camera_reg, camera_next;
    logic [15:0]        wifi_reg, wifi_next;
    logic [15:0]        ble_reg, ble_next;
    logic [7:0]         dev_state_reg, dev_state_next;
    logic [7:0]         gps_state_reg, gps_state_next;
    logic [7:0]         cap_state_reg, cap_state_next;
    logic signed [7:0]  rssi_reg, rssi_next;

    logic [COUNTER_WIDTH-1:0] cnt_reg [NUM_COUNTERS];
    logic [NUM_COUNTERS-1:0]  bump;

    // result register
    logic                  out_valid_reg;
    logic [M_TDATA_W-1:0]  out_data_reg, out_data_next;

    logic                    advance;
    logic                    take_byte;
    logic                    shadow_we;
    logic                    crc_low_we;
    logic [SHADOW_IDX_W-1:0] shadow_idx;
    logic [COUNT_W-1:0]      count_inc;
    logic [15:0]             crc_upd;
    verdict_t                fault_upd;
    verdict_t                verdict;
    link_t                   link;
    logic [31:0]             count_value;

    // The result register frees up when empty or when its word is taken.
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign cfg_ready = 1'b1;

    assign take_byte  = (in_mode_reg == MODE_BYTE) && enable_reg;
    assign shadow_idx = SHADOW_IDX_W'(byte_count_reg - COUNT_W'(PAYLOAD_START));

    always_comb begin
        byte_count_next = byte_count_reg;
        crc_next        = crc_reg;
        fault_next      = fault_reg;
        seen_next       = seen_reg;
        age_next        = age_reg;
        shadow_we       = 1'b0;
        crc_low_we      = 1'b0;
        verdict         = VERDICT_NONE;
        count_value     = '0;
        bump            = '0;
        crc_upd         = crc_reg;
        fault_upd       = fault_reg;
        count_inc       = byte_count_reg;

        seq_next       = seq_reg;
        uptime_next    = uptime_reg;
        camera_next    = camera_reg;
        wifi_next      = wifi_reg;
        ble_next       = ble_reg;
        dev_state_next = dev_state_reg;
        gps_state_next = gps_state_reg;
        cap_state_next = cap_state_reg;
        rssi_next      = rssi_reg;

        unique case (in_mode_reg)
            MODE_BYTE: begin
                if (take_byte) begin
                    if (byte_count_reg < COUNT_W'(CRC_BYTES)) begin
                        crc_upd = crc16_byte(crc_reg, in_data_reg);
                    end
                    // header checks, first fault wins
                    if (fault_reg == VERDICT_NONE) begin
                        if ((byte_count_reg == COUNT_W'(0) && in_data_reg != MAGIC_0) ||
                            (byte_count_reg == COUNT_W'(1) && in_data_reg != MAGIC_1)) begin
                            fault_upd = VERDICT_MAGIC;
                        end else if (byte_count_reg == COUNT_W'(2) &&
                                     in_data_reg != exp_version_reg) begin
                            fault_upd = VERDICT_VERSION;
                        end else if (byte_count_reg == COUNT_W'(3) &&
                                     in_data_reg != exp_type_reg) begin
                            fault_upd = VERDICT_TYPE;
                        end
                    end
                    shadow_we  = (byte_count_reg >= COUNT_W'(PAYLOAD_START)) &&
                                 (byte_count_reg < COUNT_W'(CRC_BYTES));
                    crc_low_we = (byte_count_reg == COUNT_W'(CRC_BYTES));
                    if (byte_count_reg < COUNT_W'(COUNT_SAT)) begin
                        count_inc = byte_count_reg + COUNT_W'(1);
                    end

                    if (in_last_reg) begin
                        if (count_inc != COUNT_W'(FRAME_BYTES)) begin
                            verdict = VERDICT_LENGTH;
                        end else if (fault_upd != VERDICT_NONE) begin
                            verdict = fault_upd;
                        end else if ({in_data_reg, crc_low_reg} != crc_upd) begin
                            verdict = VERDICT_CRC;
                        end else begin
                            verdict = VERDICT_OK;
                        end

                        bump[CNT_RAW] = 1'b1;
                        if (verdict == VERDICT_OK) begin
                            bump[CNT_VALID] = 1'b1;
                            seen_next       = 1'b1;
                            age_next        = '0;
                            // all payload bytes already sit in the shadow
                            seq_next       = {shadow_reg[3], shadow_reg[2],
                                              shadow_reg[1], shadow_reg[0]};
                            uptime_next    = {shadow_reg[7], shadow_reg[6],
                                              shadow_reg[5], shadow_reg[4]};
                            camera_next    = {shadow_reg[9], shadow_reg[8]};
                            wifi_next      = {shadow_reg[11], shadow_reg[10]};
                            ble_next       = {shadow_reg[13], shadow_reg[12]};
                            dev_state_next = shadow_reg[14];
                            gps_state_next = shadow_reg[15];
                            cap_state_next = shadow_reg[16];
                            rssi_next      = shadow_reg[17];
                        end else begin
                            bump[CNT_INVALID] = 1'b1;
                            bump[3'(verdict) + 3'd1] = 1'b1;
                        end
                        // restart assembly after any frame end
                        byte_count_next = '0;
                        crc_next        = CRC_INIT;
                        fault_next      = VERDICT_NONE;
                    end else begin
                        byte_count_next = count_inc;
                        crc_next        = crc_upd;
                        fault_next      = fault_upd;
                    end
                end
            end
            MODE_TICK: begin
                if (age_reg != AGE_MAX) begin
                    age_next = age_reg + AGE_W'(1);
                end
            end
            MODE_READ: begin
                count_value = 32'(cnt_reg[in_sel_reg]);
            end
            default: begin
            end
        endcase

        if (!enable_reg) begin
            link = LINK_OFF;
        end else if (!seen_next) begin
            link = LINK_NO_PACKET;
        end else if (age_next > {1'b0, stale_limit_reg}) begin
            link = LINK_STALE;
        end else begin
            link = LINK_UP;
        end

        out_data_next = {3'b000, count_value, rssi_next, cap_state_next, gps_state_next,
                         dev_state_next, ble_next, wifi_next, camera_next, uptime_next,
                         seq_next, link, verdict};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg      <= 1'b0;
            stale_limit_reg <= 16'd15000;
            exp_version_reg <= 8'h01;
            exp_type_reg    <= 8'h01;
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            byte_count_reg  <= '0;
            crc_reg         <= CRC_INIT;
            fault_reg       <= VERDICT_NONE;
            seen_reg        <= 1'b0;
            age_reg         <= '0;
            seq_reg         <= '0;
            uptime_reg      <= '0;
            camera_reg      <= '0;
            wifi_reg        <= '0;
            ble_reg         <= '0;
            dev_state_reg   <= '0;
            gps_state_reg   <= '0;
            cap_state_reg   <= '0;
            rssi_reg        <= '0;
            for (int k = 0; k < NUM_COUNTERS; k++) begin
                cnt_reg[k] <= '0;
            end
        end else begin
            // input register
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            // result register
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end

            if (advance) begin
                byte_count_reg <= byte_count_next;
                crc_reg        <= crc_next;
                fault_reg      <= fault_next;
                seen_reg       <= seen_next;
                age_reg        <= age_next;
                seq_reg        <= seq_next;
                uptime_reg     <= uptime_next;
                camera_reg     <= camera_next;
                wifi_reg       <= wifi_next;
                ble_reg        <= ble_next;
                dev_state_reg  <= dev_state_next;
                gps_state_reg  <= gps_state_next;
                cap_state_reg  <= cap_state_next;
                rssi_reg       <= rssi_next;
                for (int k = 0; k < NUM_COUNTERS; k++) begin
                    if (bump[k]) begin
                        cnt_reg[k] <= cnt_reg[k] + COUNTER_WIDTH'(1);
                    end
                end
            end

            // config writes land last; disable drops the link and the frame
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    CFG_ENABLE: begin
                        enable_reg <= cfg_data[0];
                        if (!cfg_data[0]) begin
                            seen_reg       <= 1'b0;
                            byte_count_reg <= '0;
                            crc_reg        <= CRC_INIT;
                            fault_reg      <= VERDICT_NONE;
                        end
                    end
                    CFG_STALE_LIMIT: stale_limit_reg <= cfg_data;
                    CFG_VERSION:     exp_version_reg <= cfg_data[7:0];
                    CFG_TYPE:        exp_type_reg    <= cfg_data[7:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_tready) begin
            in_mode_reg <= s_tuser[1:0];
            in_sel_reg  <= s_tuser[4:2];
            in_data_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (advance) begin
            out_data_reg <= out_data_next;
            if (shadow_we) begin
                shadow_reg[shadow_idx] <= in_data_reg;
            end
            if (crc_low_we) begin
                crc_low_reg <= in_data_reg;
            end
        end
    end

    // ---------------- assertions ----------------

    // byte count saturates, never runs past its ceiling
    assert property (@(posedge aclk) disable iff (!aresetn)
        byte_count_reg <= COUNT_W'(COUNT_SAT))
        else $error("byte count past saturation");

    // disabled receiver keeps the assembly parked at its start
    assert property (@(posedge aclk) disable iff (!aresetn)
        !enable_reg |-> (byte_count_reg == '0 && crc_reg == CRC_INIT &&
                         fault_reg == VERDICT_NONE))
        else $error("frame assembly moved while disabled");

    // a good frame marks the link seen with fresh age
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && verdict == VERDICT_OK) |=> (seen_reg && age_reg == '0))
        else $error("accepted frame did not refresh link");

    // a result from a disabled receiver reports the link off
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && !enable_reg) |=> (out_data_reg[4:3] == LINK_OFF))
        else $error("link state wrong while disabled");

endmodule

// File: verif/tb.sv
module tb;
    import sfr_pkg::*;

    // One result word, split into its fields.
    typedef struct {
        verdict_t    verdict;
        link_t       link;
        logic [31:0] sequence_no;
        logic [31:0] uptime;
        logic [15:0] cameras;
        logic [15:0] wifi_nets;
        logic [15:0] ble_devs;
        logic [7:0]  dev_state;
        logic [7:0]  gps_fix;
        logic [7:0]  cap_state;
        logic [7:0]  rssi;
        logic [31:0] count_val;
    } status_word_t;

    // Ways to damage a well-formed frame.
    typedef enum int {
        SPOIL_NONE,
        SPOIL_MAGIC0,
        SPOIL_MAGIC1,
        SPOIL_VERSION,
        SPOIL_TYPE,
        SPOIL_PAYLOAD,
        SPOIL_CRC,
        SPOIL_SHORT,
        SPOIL_LONG,
        SPOIL_SHORT_MAGIC
    } spoil_t;

    typedef enum int {
        FILL_RANDOM,
        FILL_ONES,
        FILL_ZEROS
    } fill_t;

    localparam int MAX_FRAME = 30;
    localparam int HOLD_CYCLES = 300;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;    // data_byte[7:0]
    logic [S_TUSER_W-1:0]  s_tuser;    // mode[1:0], counter_select[4:2]
    logic                  s_tlast;    // frame_last
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    status_frame_receiver_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 aclk = ~aclk;

    // ---------------------------------------------------------------
    // Receiver-side mirror: config, frame assembly, latched fields,
    // counters and link age.
    // ---------------------------------------------------------------
    logic         rx_enable;
    logic [15:0]  stale_limit;
    logic [7:0]   want_version;
    logic [7:0]   want_type;
    logic [4:0]   rx_count;
    logic [15:0]  rx_crc;
    verdict_t     rx_fault;
    logic [7:0]   shadow_bytes [SHADOW_BYTES];
    logic [7:0]   crc_lo;
    status_word_t held;
    logic [31:0]  frame_counts [NUM_COUNTERS];
    logic         seen;
    logic [AGE_W-1:0] age_ms;

    status_word_t expected_words [$];
    status_word_t want_w;
    status_word_t got_w;

    int fail_count;
    int items_sent;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_left;
    logic [7:0] frame_buf [MAX_FRAME];

    // CRC-16/CCITT-FALSE, bit-serial form
    function automatic logic [15:0] crc_ccitt_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic fb;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = c[15] ^ b[i];
            c = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
        end
        return c;
    endfunction

    function automatic void restart_assembly();
        rx_count = '0;
        rx_crc   = CRC_INIT;
        rx_fault = VERDICT_NONE;
    endfunction

    // Advance the mirror by one accepted word and return the result it should give.
    function automatic status_word_t predict_word(input mode_t mode, input logic [7:0] b,
                                                  input logic last, input logic [2:0] sel);
        status_word_t w;
        verdict_t v;
        logic [31:0] cval;
        int pos;
        v = VERDICT_NONE;
        cval = '0;
        case (mode)
            MODE_BYTE: if (rx_enable) begin
                pos = rx_count;
                if (pos < CRC_BYTES) rx_crc = crc_ccitt_step(rx_crc, b);
                // only the first header fault is kept
                if (rx_fault == VERDICT_NONE) begin
                    if ((pos == 0 && b != MAGIC_0) || (pos == 1 && b != MAGIC_1))
                        rx_fault = VERDICT_MAGIC;
                    else if (pos == 2 && b != want_version)
                        rx_fault = VERDICT_VERSION;
                    else if (pos == 3 && b != want_type)
                        rx_fault = VERDICT_TYPE;
                end
                if (pos >= PAYLOAD_START && pos < CRC_BYTES) shadow_bytes[pos - PAYLOAD_START] = b;
                if (pos == CRC_BYTES) crc_lo = b;
                if (rx_count < COUNT_SAT) rx_count++;
                if (last) begin
                    frame_counts[CNT_RAW]++;
                    if (rx_count != FRAME_BYTES) v = VERDICT_LENGTH;
                    else if (rx_fault != VERDICT_NONE) v = rx_fault;
                    else if ({b, crc_lo} != rx_crc) v = VERDICT_CRC;
                    else v = VERDICT_OK;
                    if (v == VERDICT_OK) begin
                        held.sequence_no = {shadow_bytes[3], shadow_bytes[2],
                                            shadow_bytes[1], shadow_bytes[0]};
                        held.uptime      = {shadow_bytes[7], shadow_bytes[6],
                                            shadow_bytes[5], shadow_bytes[4]};
                        held.cameras     = {shadow_bytes[9], shadow_bytes[8]};
                        held.wifi_nets   = {shadow_bytes[11], shadow_bytes[10]};
                        held.ble_devs    = {shadow_bytes[13], shadow_bytes[12]};
                        held.dev_state   = shadow_bytes[14];
                        held.gps_fix     = shadow_bytes[15];
                        held.cap_state   = shadow_bytes[16];
                        held.rssi        = shadow_bytes[17];
                        seen   = 1'b1;
                        age_ms = '0;
                        frame_counts[CNT_VALID]++;
                    end else begin
                        // reason counters sit one slot above the verdict code
                        frame_counts[CNT_INVALID]++;
                        frame_counts[int'(v) + 1]++;
                    end
                    restart_assembly();
                end
            end
            MODE_TICK: if (age_ms != AGE_MAX) age_ms++;
            MODE_READ: cval = frame_counts[sel];
            default: ;
        endcase
        w = held;
        w.verdict = v;
        w.count_val = cval;
        if (!rx_enable) w.link = LINK_OFF;
        else if (!seen) w.link = LINK_NO_PACKET;
        else if (age_ms > stale_limit) w.link = LINK_STALE;
        else w.link = LINK_UP;
        return w;
    endfunction

    function automatic status_word_t unpack_word(input logic [M_TDATA_W-1:0] d);
        status_word_t w;
        w.verdict     = verdict_t'(d[2:0]);
        w.link        = link_t'(d[4:3]);
        w.sequence_no = d[36:5];
        w.uptime      = d[68:37];
        w.cameras     = d[84:69];
        w.wifi_nets   = d[100:85];
        w.ble_devs    = d[116:101];
        w.dev_state   = d[124:117];
        w.gps_fix     = d[132:125];
        w.cap_state   = d[140:133];
        w.rssi        = d[148:141];
        w.count_val   = d[180:149];
        return w;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            fail_count++;
            if (fail_count <= 10)
                $display("mismatch on %s: expected 0x%0h, got 0x%0h", name, want, got);
        end
    endtask

    // Result checker: every word taken from the block is matched to the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_words.size() == 0) begin
                fail_count++;
                if (fail_count <= 10) $display("result word with nothing expected: 0x%h", m_tdata);
            end else begin
                want_w = expected_words.pop_front();
                got_w  = unpack_word(m_tdata);
                check_field("frame_verdict", want_w.verdict,     got_w.verdict);
                check_field("link_state",    want_w.link,        got_w.link);
                check_field("sequence_res",  want_w.sequence_no, got_w.sequence_no);
                check_field("uptime_s",      want_w.uptime,      got_w.uptime);
                check_field("camera_count",  want_w.cameras,     got_w.cameras);
                check_field("wifi_count",    want_w.wifi_nets,   got_w.wifi_nets);
                check_field("ble_count",     want_w.ble_devs,    got_w.ble_devs);
                check_field("device_state",  want_w.dev_state,   got_w.dev_state);
                check_field("gps_state",     want_w.gps_fix,     got_w.gps_fix);
                check_field("capture_state", want_w.cap_state,   got_w.cap_state);
                check_field("gateway_rssi",  want_w.rssi,        got_w.rssi);
                check_field("count_value",   want_w.count_val,   got_w.count_val);
            end
        end
    end

    // Result-side ready: random stalls, or a counted hold-off when one is requested.
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    task automatic send_word(input mode_t mode, input logic [7:0] b, input logic last,
                             input logic [2:0] sel);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= {sel, mode};
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        expected_words.push_back(predict_word(mode, b, last, sel));
        items_sent++;
    endtask

    // tick / read / unused-mode word with junk in the other fields
    task automatic send_misc(input mode_t mode, input logic [2:0] sel);
        send_word(mode, 8'($urandom), 1'($urandom), sel);
    endtask

    // Stop offering, wait out every result, then let the pipeline settle.
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_words.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [15:0] value);
        drain_results();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_ENABLE: begin
                rx_enable = value[0];
                if (!value[0]) begin
                    seen = 1'b0;
                    restart_assembly();
                end
            end
            CFG_STALE_LIMIT: stale_limit = value;
            CFG_VERSION:     want_version = value[7:0];
            CFG_TYPE:        want_type = value[7:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Well-formed frame for the current version/type settings.
    function automatic void build_frame(input fill_t fill);
        logic [15:0] c;
        frame_buf[0] = MAGIC_0;
        frame_buf[1] = MAGIC_1;
        frame_buf[2] = want_version;
        frame_buf[3] = want_type;
        for (int k = PAYLOAD_START; k < CRC_BYTES; k++)
            frame_buf[k] = (fill == FILL_RANDOM) ? 8'($urandom) :
                           (fill == FILL_ONES) ? 8'hFF : 8'h00;
        if (fill == FILL_ZEROS) frame_buf[CRC_BYTES - 1] = 8'h80;  // most negative rssi
        c = 16'hFFFF;
        for (int k = 0; k < CRC_BYTES; k++) c = crc_ccitt_step(c, frame_buf[k]);
        frame_buf[CRC_BYTES]     = c[7:0];
        frame_buf[CRC_BYTES + 1] = c[15:8];
    endfunction

    // Damage the frame in the buffer; returns the byte count to send.
    function automatic int spoil_frame(input spoil_t kind);
        int len;
        int at;
        len = FRAME_BYTES;
        at = 0;
        case (kind)
            SPOIL_MAGIC0:  at = 0;
            SPOIL_MAGIC1:  at = 1;
            SPOIL_VERSION: at = 2;
            SPOIL_TYPE:    at = 3;
            SPOIL_PAYLOAD: at = $urandom_range(PAYLOAD_START, CRC_BYTES - 1);
            SPOIL_CRC:     at = $urandom_range(CRC_BYTES, FRAME_BYTES - 1);
            SPOIL_SHORT:   len = $urandom_range(1, FRAME_BYTES - 1);
            SPOIL_LONG: begin
                len = $urandom_range(FRAME_BYTES + 1, MAX_FRAME);
                for (int k = FRAME_BYTES; k < len; k++) frame_buf[k] = 8'($urandom);
            end
            SPOIL_SHORT_MAGIC: len = $urandom_range(1, FRAME_BYTES - 1);
            default: ;
        endcase
        if (kind inside {[SPOIL_MAGIC0:SPOIL_CRC], SPOIL_SHORT_MAGIC})
            frame_buf[at] = frame_buf[at] ^ 8'($urandom_range(1, 255));
        return len;
    endfunction

    // Send the first len buffer bytes; tlast on the final one only if close is set.
    task automatic send_frame(input int len, input logic close);
        for (int k = 0; k < len; k++)
            send_word(MODE_BYTE, frame_buf[k], close && (k == len - 1), 3'($urandom));
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    task automatic test_disabled_receiver();
        // out of reset the receiver is off: bytes ignored, ticks still age
        send_word(MODE_BYTE, MAGIC_0, 1'b0, 3'd0);
        send_word(MODE_BYTE, 8'hFF, 1'b1, 3'd7);
        send_word(MODE_TICK, 8'h00, 1'b1, 3'd0);
        send_word(MODE_READ, 8'h00, 1'b0, CNT_RAW);
        send_word(MODE_NONE, 8'hFF, 1'b1, 3'd7);
    endtask

    task automatic test_register_writes();
        write_reg(CFG_ENABLE, 16'd1);
        write_reg(CFG_STALE_LIMIT, 16'hFFFF);
        write_reg(CFG_VERSION, 16'h00FF);
        write_reg(CFG_TYPE, 16'h0000);
        build_frame(FILL_ONES);
        send_frame(FRAME_BYTES, 1'b1);
        write_reg(CFG_VERSION, 16'h0000);
        write_reg(CFG_TYPE, 16'h00FF);
        build_frame(FILL_ZEROS);
        send_frame(FRAME_BYTES, 1'b1);
        write_reg(CFG_VERSION, 16'd1);
        write_reg(CFG_TYPE, 16'd1);
    endtask

    task automatic test_drop_reasons();
        int len;
        for (int k = SPOIL_MAGIC0; k <= SPOIL_SHORT_MAGIC; k++) begin
            build_frame(FILL_RANDOM);
            len = spoil_frame(spoil_t'(k));
            send_frame(len, 1'b1);
        end
        // one-byte frame
        send_word(MODE_BYTE, MAGIC_0, 1'b1, 3'd0);
        // tlast on a tick mid-frame must not end the frame
        build_frame(FILL_RANDOM);
        send_frame(12, 1'b0);
        send_word(MODE_TICK, 8'h00, 1'b1, 3'd0);
        for (int k = 12; k < FRAME_BYTES; k++)
            send_word(MODE_BYTE, frame_buf[k], k == FRAME_BYTES - 1, 3'($urandom));
    endtask

    task automatic test_counter_reads();
        for (int k = 0; k < NUM_COUNTERS; k++) send_word(MODE_READ, 8'hA5, 1'b1, 3'(k));
    endtask

    task automatic test_link_aging();
        write_reg(CFG_STALE_LIMIT, 16'd3);
        build_frame(FILL_RANDOM);
        send_frame(FRAME_BYTES, 1'b1);
        repeat (5) send_misc(MODE_TICK, 3'($urandom));   // goes stale on the fourth
        build_frame(FILL_RANDOM);
        send_frame(FRAME_BYTES, 1'b1);
        write_reg(CFG_STALE_LIMIT, 16'd0);
        send_misc(MODE_READ, CNT_VALID);
        send_misc(MODE_TICK, 3'($urandom));
    endtask

    task automatic test_disable_midframe();
        build_frame(FILL_RANDOM);
        send_frame(10, 1'b0);
        write_reg(CFG_ENABLE, 16'd0);
        send_misc(MODE_READ, CNT_RAW);
        send_misc(MODE_TICK, 3'd0);
        write_reg(CFG_ENABLE, 16'd1);
        send_misc(MODE_READ, CNT_VALID);
        build_frame(FILL_RANDOM);
        send_frame(FRAME_BYTES, 1'b1);
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_left = HOLD_CYCLES;     // block fills, s_tready must drop
        build_frame(FILL_RANDOM);
        send_frame(FRAME_BYTES, 1'b1);
        repeat (20) send_misc(MODE_READ, 3'($urandom));
        drain_results();
    endtask

    // New limit, sometimes new header settings, between bursts; sometimes a short off period.
    task automatic retune_link();
        case ($urandom_range(3))
            0: write_reg(CFG_STALE_LIMIT, 16'd0);
            1: write_reg(CFG_STALE_LIMIT, 16'hFFFF);
            default: write_reg(CFG_STALE_LIMIT, 16'($urandom_range(0, 40)));
        endcase
        if ($urandom_range(1)) begin
            write_reg(CFG_VERSION, 16'($urandom_range(0, 255)));
            write_reg(CFG_TYPE, 16'($urandom_range(0, 255)));
        end
        if ($urandom_range(99) < 20) begin
            write_reg(CFG_ENABLE, 16'd0);
            repeat ($urandom_range(1, 3)) send_misc(MODE_TICK, 3'($urandom));
            send_word(MODE_BYTE, 8'($urandom), 1'($urandom), 3'($urandom));
            write_reg(CFG_ENABLE, 16'd1);
        end
    endtask

    task automatic run_traffic(input int tx_idle, input int rx_idle, input int n_items);
        int stop_at;
        int chunk_end;
        int r;
        int len;
        send_idle_pct = tx_idle;
        recv_idle_pct = rx_idle;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            retune_link();
            chunk_end = items_sent + 110;
            while (items_sent < chunk_end) begin
                r = $urandom_range(99);
                if (r < 60) begin
                    // mostly good frames, some damaged
                    build_frame(FILL_RANDOM);
                    len = FRAME_BYTES;
                    if ($urandom_range(99) < 35)
                        len = spoil_frame(spoil_t'($urandom_range(SPOIL_MAGIC0, SPOIL_SHORT_MAGIC)));
                    send_frame(len, 1'b1);
                end else if (r < 80) begin
                    repeat ($urandom_range(1, 6)) send_misc(MODE_TICK, 3'($urandom));
                end else if (r < 90) begin
                    send_misc(MODE_READ, 3'($urandom));
                end else if (r < 94) begin
                    send_misc(MODE_NONE, 3'($urandom));
                end else begin
                    // stray bytes
                    repeat ($urandom_range(1, 4))
                        send_word(MODE_BYTE, 8'($urandom), $urandom_range(99) < 30, 3'($urandom));
                end
            end
        end
    endtask

    // ---------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------
    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        s_tlast   = 1'b0;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_ENABLE;
        cfg_data  = '0;
        fail_count    = 0;
        items_sent    = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_left     = 0;

        // mirror reset state
        rx_enable    = 1'b0;
        stale_limit  = 16'd15000;
        want_version = 8'h01;
        want_type    = 8'h01;
        restart_assembly();
        for (int k = 0; k < SHADOW_BYTES; k++) shadow_bytes[k] = '0;
        crc_lo = '0;
        held = '{VERDICT_NONE, LINK_OFF, 32'd0, 32'd0, 16'd0, 16'd0, 16'd0,
                 8'd0, 8'd0, 8'd0, 8'd0, 32'd0};
        for (int k = 0; k < NUM_COUNTERS; k++) frame_counts[k] = '0;
        seen   = 1'b0;
        age_ms = '0;

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_disabled_receiver();
        test_register_writes();
        test_drop_reasons();
        test_counter_reads();
        test_link_aging();
        test_disable_midframe();
        test_backpressure();
        run_traffic(30, 88, 350);
        run_traffic(88, 30, 350);
        run_traffic(0, 0, 350);

        drain_results();
        repeat (8) @(posedge aclk);
        if (fail_count == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

    // watchdog
    initial begin
        #3000000;
        $display("tb: FAIL");
        $finish;
    end

endmodule
